// ----- design/voxel_grid_hollow_fill_macros.svh -----
// Assertion macros shared by the checker of the voxel grid hollow fill block.
// Depends on nothing; included by the checker file.
`ifndef VOXEL_GRID_HOLLOW_FILL_MACROS_SVH
`define VOXEL_GRID_HOLLOW_FILL_MACROS_SVH
`define VG_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("port check failed");
`define VG_ASSERT_MSG(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`endif

// ----- design/vghf_pkg.sv -----
// Package for the voxel grid hollow fill block: sizes, class codes, op codes, types.
// Depends on nothing.
`timescale 1ns / 1ps
package vghf_pkg;
    localparam int MaxX = 32;
    localparam int MaxY = 32;
    localparam int MaxZ = 32;
    localparam int XW = $clog2(MaxX);
    localparam int YW = $clog2(MaxY);
    localparam int ZW = $clog2(MaxZ);
    localparam int AW = XW + YW + ZW;
    localparam int Cells = MaxX * MaxY * MaxZ;
    localparam int PW = AW + 1;

    typedef logic [1:0] class_t;
    localparam class_t OccEmpty = 2'd0;
    localparam class_t OccSurface = 2'd1;
    localparam class_t OccInterior = 2'd2;
    localparam class_t OccExterior = 2'd3;

    localparam logic [1:0] OpWrite = 2'd0;
    localparam logic [1:0] OpFill = 2'd1;
    localparam logic [1:0] OpRead = 2'd2;

    localparam logic [1:0] RegSizeX = 2'd0;
    localparam logic [1:0] RegSizeY = 2'd1;
    localparam logic [1:0] RegSizeZ = 2'd2;

    typedef struct packed {
        logic we;
        logic [AW-1:0] waddr;
        class_t wdata;
        logic [AW-1:0] raddr;
    } store_req_t;

    function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] x,
        input logic [YW-1:0] y, input logic [ZW-1:0] z);
        cell_addr = {z, y, x};
    endfunction
endpackage

// ----- design/vghf_class_store.sv -----
// Class store: one two-bit class per voxel with a registered synchronous read,
// plus a per-voxel epoch-free reset pass handled by the controller. Uses vghf_pkg.
`timescale 1ns / 1ps
module vghf_class_store
    import vghf_pkg::*;
(
    input  logic       clk,
    input  store_req_t req,
    output class_t     rdata
);
    class_t mem [Cells];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end
endmodule

// ----- design/vghf_queue.sv -----
// Flood queue memory: voxel addresses written at one port, read at another,
// read data registered. Uses vghf_pkg.
`timescale 1ns / 1ps
module vghf_queue
    import vghf_pkg::*;
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [AW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [AW-1:0] rdata
);
    logic [AW-1:0] mem [Cells];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- design/voxel_grid_hollow_fill.sv -----
// Voxel grid hollow fill: 32x32x32 class store with write, read and flood fill.
// A write or an out-of-range read is done from idle; an in-range read first passes StRead.
// A fill seeds by marking every empty boundary voxel exterior and queueing it, then floods:
// it pops each queued voxel and marks and queues its empty in-grid neighbors the same way.
// Last it marks every voxel still empty interior and counts it. After reset a clearing pass
// empties the store, with busy high. The receiver cannot stall: done is a one-cycle strobe.
`timescale 1ns / 1ps
module voxel_grid_hollow_fill
    import vghf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [5:0]  cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [4:0]  pos_x,
    input  logic [4:0]  pos_y,
    input  logic [4:0]  pos_z,
    input  logic        is_surface,
    output logic        done,
    output logic [1:0]  voxel_class,
    output logic [15:0] interior_count
);
    typedef enum logic [10:0] {
        StClear  = 11'b00000000001,
        StIdle   = 11'b00000000010,
        StRead   = 11'b00000000100,
        StSeedRd = 11'b00000001000,
        StSeedWr = 11'b00000010000,
        StPop    = 11'b00000100000,
        StPopWt  = 11'b00001000000,
        StNbRd   = 11'b00010000000,
        StNbWr   = 11'b00100000000,
        StFinRd  = 11'b01000000000,
        StFinWr  = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic [5:0] sx_reg, sy_reg, sz_reg;
    logic [XW-1:0] x_reg, x_next;
    logic [YW-1:0] y_reg, y_next;
    logic [ZW-1:0] z_reg, z_next;
    logic [XW-1:0] cx_reg, cx_next;
    logic [YW-1:0] cy_reg, cy_next;
    logic [ZW-1:0] cz_reg, cz_next;
    logic [2:0] dir_reg, dir_next;
    logic [PW-1:0] rp_reg, rp_next, wp_reg, wp_next;
    logic [15:0] cnt_reg, cnt_next;
    logic done_reg, done_next;
    class_t vc_reg, vc_next;
    logic [15:0] ic_reg, ic_next;

    store_req_t sreq;
    class_t srd;
    logic qwe;
    logic [AW-1:0] qrd;

    logic [5:0] cfg_val;
    logic in_pos;
    logic boundary;
    logic last_cell;
    logic nb_ok;
    logic [XW-1:0] nx;
    logic [YW-1:0] ny;
    logic [ZW-1:0] nz;

    vghf_class_store u_store (.clk(clk), .req(sreq), .rdata(srd));
    vghf_queue u_queue (.clk(clk), .we(qwe), .waddr(wp_reg[AW-1:0]),
        .wdata(cell_addr(x_reg, y_reg, z_reg)), .raddr(rp_reg[AW-1:0]), .rdata(qrd));

    assign cfg_val = (cfg_data == 6'd0) ? 6'd1 : ((cfg_data > 6'(MaxX)) ? 6'(MaxX) : cfg_data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sx_reg <= 6'(MaxX);
            sy_reg <= 6'(MaxY);
            sz_reg <= 6'(MaxZ);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                RegSizeX: sx_reg <= cfg_val;
                RegSizeY: sy_reg <= cfg_val;
                RegSizeZ: sz_reg <= cfg_val;
                default: ;
            endcase
        end
    end

    assign in_pos = ({1'b0, pos_x} < sx_reg) && ({1'b0, pos_y} < sy_reg)
        && ({1'b0, pos_z} < sz_reg);
    assign boundary = (x_reg == '0) || (y_reg == '0) || (z_reg == '0)
        || ({1'b0, x_reg} == sx_reg - 6'd1) || ({1'b0, y_reg} == sy_reg - 6'd1)
        || ({1'b0, z_reg} == sz_reg - 6'd1);
    assign last_cell = ({1'b0, x_reg} == sx_reg - 6'd1) && ({1'b0, y_reg} == sy_reg - 6'd1)
        && ({1'b0, z_reg} == sz_reg - 6'd1);

    always_comb
    begin
        nx = cx_reg;
        ny = cy_reg;
        nz = cz_reg;
        nb_ok = 1'b0;
        case (dir_reg)
            3'd0:
            begin
                nx = cx_reg + 1'b1;
                nb_ok = ({1'b0, cx_reg} + 6'd1) < sx_reg;
            end
            3'd1:
            begin
                nx = cx_reg - 1'b1;
                nb_ok = cx_reg != '0;
            end
            3'd2:
            begin
                ny = cy_reg + 1'b1;
                nb_ok = ({1'b0, cy_reg} + 6'd1) < sy_reg;
            end
            3'd3:
            begin
                ny = cy_reg - 1'b1;
                nb_ok = cy_reg != '0;
            end
            3'd4:
            begin
                nz = cz_reg + 1'b1;
                nb_ok = ({1'b0, cz_reg} + 6'd1) < sz_reg;
            end
            3'd5:
            begin
                nz = cz_reg - 1'b1;
                nb_ok = cz_reg != '0;
            end
            default: nb_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        cx_next = cx_reg;
        cy_next = cy_reg;
        cz_next = cz_reg;
        dir_next = dir_reg;
        rp_next = rp_reg;
        wp_next = wp_reg;
        cnt_next = cnt_reg;
        done_next = 1'b0;
        vc_next = vc_reg;
        ic_next = ic_reg;
        sreq.we = 1'b0;
        sreq.waddr = cell_addr(x_reg, y_reg, z_reg);
        sreq.wdata = OccEmpty;
        sreq.raddr = cell_addr(x_reg, y_reg, z_reg);
        qwe = 1'b0;
        case (state_reg)
            StClear:
            begin
                sreq.we = 1'b1;
                {z_next, y_next, x_next} = {z_reg, y_reg, x_reg} + 1'b1;
                if (&{z_reg, y_reg, x_reg})
                begin
                    state_next = StIdle;
                end
            end
            StIdle:
            begin
                if (start)
                begin
                    vc_next = OccEmpty;
                    ic_next = '0;
                    sreq.raddr = cell_addr(pos_x, pos_y, pos_z);
                    case (op)
                        OpWrite:
                        begin
                            sreq.we = in_pos;
                            sreq.waddr = cell_addr(pos_x, pos_y, pos_z);
                            sreq.wdata = is_surface ? OccSurface : OccEmpty;
                            done_next = 1'b1;
                        end
                        OpRead:
                        begin
                            x_next = pos_x;
                            state_next = in_pos ? StRead : StIdle;
                            done_next = !in_pos;
                        end
                        OpFill:
                        begin
                            x_next = '0;
                            y_next = '0;
                            z_next = '0;
                            rp_next = '0;
                            wp_next = '0;
                            cnt_next = '0;
                            state_next = StSeedRd;
                        end
                        default: done_next = 1'b1;
                    endcase
                end
            end
            StRead:
            begin
                vc_next = srd;
                done_next = 1'b1;
                state_next = StIdle;
            end
            StSeedRd:
            begin
                state_next = StSeedWr;
            end
            StSeedWr:
            begin
                if (boundary && srd == OccEmpty)
                begin
                    sreq.we = 1'b1;
                    sreq.wdata = OccExterior;
                    qwe = 1'b1;
                    wp_next = wp_reg + 1'b1;
                end
                state_next = StSeedRd;
                if ({1'b0, x_reg} != sx_reg - 6'd1)
                begin
                    x_next = x_reg + 1'b1;
                end
                else
                begin
                    x_next = '0;
                    if ({1'b0, y_reg} != sy_reg - 6'd1)
                    begin
                        y_next = y_reg + 1'b1;
                    end
                    else
                    begin
                        y_next = '0;
                        if ({1'b0, z_reg} != sz_reg - 6'd1)
                        begin
                            z_next = z_reg + 1'b1;
                        end
                        else
                        begin
                            z_next = '0;
                            state_next = StPop;
                        end
                    end
                end
            end
            StPop:
            begin
                if (rp_reg == wp_next)
                begin
                    x_next = '0;
                    y_next = '0;
                    z_next = '0;
                    state_next = StFinRd;
                end
                else
                begin
                    rp_next = rp_reg + 1'b1;
                    state_next = StPopWt;
                end
            end
            StPopWt:
            begin
                {cz_next, cy_next, cx_next} = qrd;
                dir_next = 3'd0;
                state_next = StNbRd;
            end
            StNbRd:
            begin
                x_next = nx;
                y_next = ny;
                z_next = nz;
                sreq.raddr = cell_addr(nx, ny, nz);
                if (nb_ok)
                begin
                    state_next = StNbWr;
                end
                else if (dir_reg == 3'd5)
                begin
                    state_next = StPop;
                end
                else
                begin
                    dir_next = dir_reg + 1'b1;
                end
            end
            StNbWr:
            begin
                if (srd == OccEmpty)
                begin
                    sreq.we = 1'b1;
                    sreq.wdata = OccExterior;
                    qwe = 1'b1;
                    wp_next = wp_reg + 1'b1;
                end
                if (dir_reg == 3'd5)
                begin
                    state_next = StPop;
                end
                else
                begin
                    dir_next = dir_reg + 1'b1;
                    state_next = StNbRd;
                end
            end
            StFinRd:
            begin
                state_next = StFinWr;
            end
            StFinWr:
            begin
                if (srd == OccEmpty)
                begin
                    sreq.we = 1'b1;
                    sreq.wdata = OccInterior;
                    if (cnt_reg != 16'hFFFF)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                state_next = StFinRd;
                if ({1'b0, x_reg} != sx_reg - 6'd1)
                begin
                    x_next = x_reg + 1'b1;
                end
                else
                begin
                    x_next = '0;
                    if ({1'b0, y_reg} != sy_reg - 6'd1)
                    begin
                        y_next = y_reg + 1'b1;
                    end
                    else
                    begin
                        y_next = '0;
                        z_next = z_reg + 1'b1;
                    end
                end
                if (last_cell)
                begin
                    ic_next = cnt_next;
                    done_next = 1'b1;
                    state_next = StIdle;
                end
            end
            default: state_next = StIdle;
        endcase
        if (state_reg == StIdle && start && op == OpRead)
        begin
            y_next = pos_y;
            z_next = pos_z;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= StClear;
            x_reg <= '0;
            y_reg <= '0;
            z_reg <= '0;
            rp_reg <= '0;
            wp_reg <= '0;
            done_reg <= 1'b0;
            vc_reg <= OccEmpty;
            ic_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
            rp_reg <= rp_next;
            wp_reg <= wp_next;
            done_reg <= done_next;
            vc_reg <= vc_next;
            ic_reg <= ic_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg <= cx_next;
        cy_reg <= cy_next;
        cz_reg <= cz_next;
        dir_reg <= dir_next;
        cnt_reg <= cnt_next;
    end

    assign busy = state_reg != StIdle;
    assign done = done_reg;
    assign voxel_class = vc_reg;
    assign interior_count = ic_reg;
endmodule

// ----- design/vghf_checker.sv -----
// Port checker for the voxel grid hollow fill block, bound to the top level.
// Uses vghf_pkg and voxel_grid_hollow_fill_macros.svh.
`timescale 1ns / 1ps
`include "voxel_grid_hollow_fill_macros.svh"
module vghf_checker
    import vghf_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  op,
    input logic        done,
    input logic [1:0]  voxel_class,
    input logic [15:0] interior_count
);
    `VG_ASSERT(a_write_done, (start && !busy && op == OpWrite) |=> done)
    `VG_ASSERT(a_fill_class_zero, (done && interior_count != 16'd0) |-> voxel_class == OccEmpty)
    `VG_ASSERT(a_done_pulse, done |=> !done || $past(start && !busy))
    `VG_ASSERT(a_fill_busy, (start && !busy && op == OpFill) |=> busy)
endmodule

bind voxel_grid_hollow_fill vghf_checker u_vghf_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op),
    .done(done), .voxel_class(voxel_class), .interior_count(interior_count)
);
